// ===== sv/uclp_pkg.sv =====
// Shared types, character codes and a command decode helper for the command line parser.
package uclp_pkg;

  localparam int unsigned MaxFieldsDefault = 25;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned FieldW = 5;
  localparam int unsigned ValueW = 16;

  localparam logic [ByteW-1:0] CharCr    = 8'h0D;
  localparam logic [ByteW-1:0] CharLf    = 8'h0A;
  localparam logic [ByteW-1:0] CharSp    = 8'h20;
  localparam logic [ByteW-1:0] CharTab   = 8'h09;
  localparam logic [ByteW-1:0] CharVt    = 8'h0B;
  localparam logic [ByteW-1:0] CharFf    = 8'h0C;
  localparam logic [ByteW-1:0] CharPlus  = 8'h2B;
  localparam logic [ByteW-1:0] CharMinus = 8'h2D;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;

  typedef enum logic [1:0] {
    EV_FIELD    = 2'd0,
    EV_LINE_ERR = 2'd1,
    EV_BOOT     = 2'd2
  } ev_kind_e;

  typedef enum logic [CmdW-1:0] {
    CMD_T = 4'd0,
    CMD_C = 4'd1,
    CMD_M = 4'd2,
    CMD_D = 4'd3,
    CMD_S = 4'd4,
    CMD_G = 4'd5,
    CMD_W = 4'd6,
    CMD_K = 4'd7,
    CMD_P = 4'd8
  } cmd_e;

  // atol-style converter phase, one-hot
  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic hit;
    cmd_e code;
  } cmd_dec_t;

  function automatic cmd_dec_t decode_cmd(input logic [ByteW-1:0] c);
    cmd_dec_t r;
    r.hit  = 1'b1;
    r.code = CMD_T;
    unique case (c)
      8'h74:   r.code = CMD_T;  // t
      8'h63:   r.code = CMD_C;  // c
      8'h6D:   r.code = CMD_M;  // m
      8'h64:   r.code = CMD_D;  // d
      8'h73:   r.code = CMD_S;  // s
      8'h67:   r.code = CMD_G;  // g
      8'h77:   r.code = CMD_W;  // w
      8'h6B:   r.code = CMD_K;  // k
      8'h70:   r.code = CMD_P;  // p
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/uart_command_line_parser_core.sv =====
// Serial command line parser: command detection, field conversion, result register.
//
// Takes one received character per transaction and produces at most one result
// transaction per character. Idle: a command letter (t c m d s g w k p) followed
// by a space opens a line without output; "0 " reports a bootloader jump request;
// a CR not preceded by LF or an LF not preceded by CR reports a line error. In a
// line, each character other than space/CR/LF feeds an atol-style converter
// (leading TAB/VT/FF skipped, optional sign, digits until the first non-digit,
// 16-bit wrap). Space, CR or LF reports the field with its position; CR/LF also
// flags line_done and returns to idle. Fields at or beyond MaxFields report value
// 0 with field_dropped set; the field number saturates at 31.
// Timing: a character is held in the input register, the decode and the
// multiply-by-ten accumulate run combinationally on it, and the result lands in the
// output register, and a character is taken every cycle. The
// input side only waits when the output register still holds an untaken result
// and the pending character would produce another one.
module uart_command_line_parser_core #(
  parameter int unsigned MaxFields = uclp_pkg::MaxFieldsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [uclp_pkg::ByteW-1:0]        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        event_kind_o,
  output logic [uclp_pkg::CmdW-1:0]         command_code_o,
  output logic [uclp_pkg::FieldW-1:0]       field_number_o,
  output logic signed [uclp_pkg::ValueW-1:0] field_value_o,
  output logic                              field_dropped_o,
  output logic                              line_done_o
);

  localparam logic [uclp_pkg::FieldW-1:0] MaxFieldsW = uclp_pkg::FieldW'(MaxFields);
  localparam logic [uclp_pkg::FieldW-1:0] CountSat   = '1;

  // input register
  logic                      s1_valid_q;
  logic [uclp_pkg::ByteW-1:0] byte_q;

  // parser state
  logic                        in_line_q, in_line_d;
  logic [uclp_pkg::ByteW-1:0]  prev_q;
  uclp_pkg::cmd_e              cmd_q, cmd_d;
  logic [uclp_pkg::FieldW-1:0] count_q, count_d;
  logic [uclp_pkg::ValueW-1:0] acc_q, acc_d;
  logic                        neg_q, neg_d;
  uclp_pkg::phase_e            phase_q, phase_d;

  // result register
  logic                        out_valid_q;
  uclp_pkg::ev_kind_e          kind_q, kind_d;
  uclp_pkg::cmd_e              rcmd_q;
  logic [uclp_pkg::FieldW-1:0] num_q, num_d;
  logic [uclp_pkg::ValueW-1:0] val_q, val_d;
  logic                        drop_q, drop_d;
  logic                        done_q, done_d;

  logic                        emit;
  logic                        advance;
  logic                        is_digit;
  logic                        is_blank;
  logic                        is_term;
  logic [uclp_pkg::ValueW-1:0] digit_val;
  logic [uclp_pkg::ValueW-1:0] acc_x10;
  logic [uclp_pkg::ValueW-1:0] signed_val;
  uclp_pkg::cmd_dec_t          prev_cmd;

  assign is_digit  = (byte_q >= uclp_pkg::CharZero) && (byte_q <= uclp_pkg::CharNine);
  assign is_blank  = (byte_q == uclp_pkg::CharTab) || (byte_q == uclp_pkg::CharVt) ||
                     (byte_q == uclp_pkg::CharFf);
  assign is_term   = (byte_q == uclp_pkg::CharSp) || (byte_q == uclp_pkg::CharCr) ||
                     (byte_q == uclp_pkg::CharLf);
  assign digit_val = {{(uclp_pkg::ValueW-uclp_pkg::ByteW){1'b0}},
                      byte_q - uclp_pkg::CharZero};
  // x10 as shift-and-add, wraps to 16 bits like the reference cast
  assign acc_x10    = {acc_q[uclp_pkg::ValueW-4:0], 3'b000} +
                      {acc_q[uclp_pkg::ValueW-2:0], 1'b0};
  assign signed_val = neg_q ? (uclp_pkg::ValueW'(0) - acc_q) : acc_q;
  assign prev_cmd   = uclp_pkg::decode_cmd(prev_q);

  always_comb begin
    emit      = 1'b0;
    in_line_d = in_line_q;
    cmd_d     = cmd_q;
    count_d   = count_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    phase_d   = phase_q;
    kind_d    = uclp_pkg::EV_FIELD;
    num_d     = '0;
    val_d     = '0;
    drop_d    = 1'b0;
    done_d    = 1'b0;

    if (!in_line_q) begin
      count_d = '0;
      if (byte_q == uclp_pkg::CharCr) begin
        if (prev_q != uclp_pkg::CharLf) begin
          emit   = 1'b1;
          kind_d = uclp_pkg::EV_LINE_ERR;
        end
      end else if (byte_q == uclp_pkg::CharLf) begin
        if (prev_q != uclp_pkg::CharCr) begin
          emit   = 1'b1;
          kind_d = uclp_pkg::EV_LINE_ERR;
        end
      end else if (byte_q == uclp_pkg::CharSp) begin
        if (prev_q == uclp_pkg::CharZero) begin
          emit   = 1'b1;
          kind_d = uclp_pkg::EV_BOOT;
        end else if (prev_cmd.hit) begin
          cmd_d     = prev_cmd.code;
          in_line_d = 1'b1;
          acc_d     = '0;
          neg_d     = 1'b0;
          phase_d   = uclp_pkg::PH_START;
        end
      end
    end else if (!is_term) begin
      unique case (phase_q) inside
        uclp_pkg::PH_START: begin
          if (is_blank) begin
            phase_d = uclp_pkg::PH_START;
          end else if ((byte_q == uclp_pkg::CharPlus) || (byte_q == uclp_pkg::CharMinus)) begin
            neg_d   = (byte_q == uclp_pkg::CharMinus);
            phase_d = uclp_pkg::PH_SIGN;
          end else if (is_digit) begin
            acc_d   = digit_val;
            phase_d = uclp_pkg::PH_DIGITS;
          end else begin
            phase_d = uclp_pkg::PH_STOP;
          end
        end
        uclp_pkg::PH_SIGN, uclp_pkg::PH_DIGITS: begin
          if (is_digit) begin
            acc_d   = acc_x10 + digit_val;
            phase_d = uclp_pkg::PH_DIGITS;
          end else begin
            phase_d = uclp_pkg::PH_STOP;
          end
        end
        default: phase_d = phase_q;
      endcase
    end else begin
      // field terminator: report, then reset the converter
      emit    = 1'b1;
      kind_d  = uclp_pkg::EV_FIELD;
      num_d   = count_q;
      drop_d  = (count_q >= MaxFieldsW);
      val_d   = drop_d ? '0 : signed_val;
      done_d  = (byte_q != uclp_pkg::CharSp);
      count_d = (count_q != CountSat) ? count_q + 1'b1 : count_q;
      acc_d   = '0;
      neg_d   = 1'b0;
      phase_d = uclp_pkg::PH_START;
      if (done_d) begin
        in_line_d = 1'b0;
        count_d   = '0;
      end
    end
  end

  // a character that yields nothing can pass even with the result register full
  assign advance    = s1_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      in_line_q   <= 1'b0;
      prev_q      <= '0;
      cmd_q       <= uclp_pkg::CMD_T;
      count_q     <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      phase_q     <= uclp_pkg::PH_START;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        in_line_q <= in_line_d;
        prev_q    <= byte_q;
        cmd_q     <= cmd_d;
        count_q   <= count_d;
        acc_q     <= acc_d;
        neg_q     <= neg_d;
        phase_q   <= phase_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
    if (advance && emit) begin
      kind_q <= kind_d;
      rcmd_q <= cmd_q;
      num_q  <= num_d;
      val_q  <= val_d;
      drop_q <= drop_d;
      done_q <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = kind_q;
  assign command_code_o  = rcmd_q;
  assign field_number_o  = num_q;
  assign field_value_o   = val_q;
  assign field_dropped_o = drop_q;
  assign line_done_o     = done_q;

  // checks
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("converter phase not one-hot");

  a_non_field_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != uclp_pkg::EV_FIELD) |->
      (field_number_o == '0) && (field_value_o == '0) && !field_dropped_o && !line_done_o)
    else $error("non-field result carries field data");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_dropped_o |-> (field_value_o == '0) &&
      (field_number_o >= MaxFieldsW))
    else $error("dropped field has a value or low number");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit && done_d |=> !in_line_q && (count_q == '0))
    else $error("line end did not return to idle");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten");

endmodule
